>>> hdl/minv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package minv_pkg;

  // default operand width
  localparam int WIDTH_DEFAULT = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_REDUCE,
    ST_SIGN
  } minv_state_t;

endpackage

`default_nettype wire

>>> hdl/minv_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module minv_divider import minv_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  input  wire logic [WIDTH-1:0] mult,
  output logic                  done,
  output logic [WIDTH-1:0]      remainder,
  output logic [WIDTH-1:0]      product
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH-1:0] mul;

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] trial;
  logic           ge;

  // one restoring division bit per cycle
  assign shifted = {remainder, dvd[WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign ge      = !trial[WIDTH];
  assign done    = run && (cnt == LAST);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        run <= 1'b0;
      end
    end
  end

  // datapath: remainder, and quotient times mult built msb first
  always_ff @(posedge clk) begin
    if (load) begin
      remainder <= '0;
      product   <= '0;
      dvd       <= dividend;
      dsr       <= divisor;
      mul       <= mult;
    end else if (run) begin
      remainder <= ge ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
      dvd       <= {dvd[WIDTH-2:0], 1'b0};
      product   <= {product[WIDTH-2:0], 1'b0} + (ge ? mul : '0);
    end
  end

endmodule

`default_nettype wire

>>> hdl/modular_inverse.sv
`timescale 1ns / 1ps
`default_nettype none

// Modular inverse by the extended Euclidean algorithm. An item is taken when
// start is high and busy is low; its result appears on inverse and exists for
// exactly one cycle with done high, and the receiver cannot hold it off.
// exists is low and inverse is zero when value and modulus share a factor,
// when value reduces to zero, or when modulus is below two. Each Euclid step
// uses the bit-serial divider that forms the remainder and the
// quotient-times-coefficient product together. busy stays high for the whole
// item.

module modular_inverse import minv_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] value,
  input  wire logic [WIDTH-1:0] modulus,
  output logic                  busy,
  output logic                  done,
  output logic [WIDTH-1:0]      inverse,
  output logic                  exists
);

  minv_state_t state;
  minv_state_t state_next;

  logic [WIDTH-1:0] u;
  logic [WIDTH-1:0] v;
  logic [WIDTH-1:0] m1;
  logic [WIDTH-1:0] m2;
  logic [WIDTH-1:0] pmod;
  logic             neg;

  logic             accept;
  logic             fail;
  logic             div_load;
  logic             div_done;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH-1:0] div_prod;

  assign accept = start && !busy;
  assign fail   = (pmod < WIDTH'(2)) || (u == '0);

  // shared iterative divide and multiply unit
  minv_divider #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (v),
    .divisor  (u),
    .mult     (m1),
    .done     (div_done),
    .remainder(div_rem),
    .product  (div_prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (fail)          state_next = ST_IDLE;
        else if (u == WIDTH'(1))    state_next = ST_REDUCE;
        else                        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_CHECK;
      ST_REDUCE: state_next = ST_SIGN;
      ST_SIGN:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy     = (state != ST_IDLE);
    div_load = (state == ST_CHECK) && !fail && (u != WIDTH'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // euclid registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          u    <= value;
          v    <= modulus;
          pmod <= modulus;
          m1   <= WIDTH'(1);
          m2   <= '0;
          neg  <= 1'b0;
        end
      end
      ST_UPDATE: begin
        v   <= u;
        u   <= div_rem;
        m2  <= m1;
        m1  <= m2 + div_prod;
        neg <= !neg;
      end
      ST_REDUCE: begin
        if (m1 >= pmod) m1 <= m1 - pmod;
      end
      default: begin
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_CHECK) && fail) || (state == ST_SIGN);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == ST_CHECK) && fail) begin
      inverse <= '0;
      exists  <= 1'b0;
    end else if (state == ST_SIGN) begin
      inverse <= (neg && (m1 != '0)) ? (pmod - m1) : m1;
      exists  <= 1'b1;
    end
  end

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an item was taken");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !exists) |-> (inverse == '0))
    else $error("no-inverse result carries a nonzero value");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && exists) |-> (inverse < pmod))
    else $error("inverse not reduced below the modulus");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

>>> bench/modular_inverse_tb.sv
`timescale 1ns / 1ps

module modular_inverse_tb;
  import minv_pkg::*;

  localparam int W           = WIDTH_DEFAULT;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE_CYCLES = 50;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         exists;
  } inverse_result_t;

  // expected inverses, one per accepted item, checked in order
  class inverse_scoreboard;
    inverse_result_t expected[$];
    int              errors = 0;

    // extended euclid on (modulus, value), coefficient kept as magnitude plus sign
    function inverse_result_t predict_inverse(logic [W-1:0] a, logic [W-1:0] p);
      longint unsigned u, v, m1, m2, q, r, m;
      bit              neg;
      inverse_result_t res;
      res.inverse = '0;
      res.exists  = 1'b0;
      if (p < 2) return res;
      u   = a;
      v   = p;
      m1  = 1;
      m2  = 0;
      neg = 1'b0;
      while (u != 1) begin
        if (u == 0) return res;
        q   = v / u;
        r   = v - q * u;
        m   = m2 + q * m1;
        v   = u;
        u   = r;
        m2  = m1;
        m1  = m;
        neg = !neg;
      end
      m1 = m1 % p;
      if (neg && m1 != 0) m1 = p - m1;
      res.inverse = m1[W-1:0];
      res.exists  = 1'b1;
      return res;
    endfunction

    function void note_item(logic [W-1:0] a, logic [W-1:0] p);
      expected.push_back(predict_inverse(a, p));
    endfunction

    function void check_result(logic [W-1:0] inv, logic ex);
      inverse_result_t want;
      if (expected.size() == 0) begin
        $error("result with no item outstanding: inverse %h exists %b", inv, ex);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (inv !== want.inverse) begin
        $error("inverse mismatch: expected %h, actual %h", want.inverse, inv);
        errors++;
      end
      if (ex !== want.exists) begin
        $error("exists mismatch: expected %b, actual %b", want.exists, ex);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         start;
  logic [W-1:0] value;
  logic [W-1:0] modulus;
  logic         busy;
  logic         done;
  logic [W-1:0] inverse;
  logic         exists;

  inverse_scoreboard sb;
  bit                gaps_on;
  int                stall_cycles;

  modular_inverse #(
    .WIDTH(W)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (value),
    .modulus(modulus),
    .busy   (busy),
    .done   (done),
    .inverse(inverse),
    .exists (exists)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // drop start while the sender pauses, with junk on the operands
  task automatic pause_sender(input int n);
    start   <= 1'b0;
    value   <= $urandom;
    modulus <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [W-1:0] a, input logic [W-1:0] p);
    if (gaps_on && $urandom_range(0, 99) < 8) pause_sender($urandom_range(1, 40));
    start   <= 1'b1;
    value   <= a;
    modulus <= p;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // accepted items and results
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(inverse, exists);
      if (start && !busy) sb.note_item(value, modulus);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [W-1:0] a, p;
    int           pick;
    sb           = new();
    stall_cycles = 0;
    gaps_on      = 1'b1;
    rst          = 1'b1;
    start        = 1'b0;
    value        = '0;
    modulus      = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, shared factors, out-of-range moduli, worst-case step count
    send_item(32'd1, 32'd2);
    send_item(32'd0, 32'd7);
    send_item(32'd7, 32'd7);
    send_item(32'd14, 32'd7);
    send_item(32'd6, 32'd9);
    send_item(32'd3, 32'd0);
    send_item(32'd3, 32'd1);
    send_item(32'd0, 32'd0);
    send_item(32'd5, 32'd2);
    send_item(32'd3, 32'd10);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd1, 32'hFFFF_FFFF);
    send_item(32'd2, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'hFFFF_FFFF);
    send_item(32'h1234_5678, 32'h8000_0000);
    send_item(32'h1234_5679, 32'h8000_0000);
    send_item(32'd1836311903, 32'd2971215073);
    send_item(32'd2971215073, 32'd1836311903);
    send_item(32'hFFFF_FFFF, 32'd2);
    send_item(32'hAAAA_AAAB, 32'h5555_5555);

    // random operands, mixing sizes and degenerate cases
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // a long stretch with the sender never idling
      gaps_on = !(i >= 100 && i < 200);
      pick = $urandom_range(0, 99);
      if (pick < 4)       p = $urandom_range(0, 1);
      else if (pick < 30) p = $urandom_range(2, 1000);
      else if (pick < 40) p = 32'd1 << $urandom_range(1, 31);
      else                p = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 5)       a = '0;
      else if (pick < 15) a = p * $urandom_range(1, 3);
      else if (pick < 30) a = $urandom_range(1, 50);
      else if (pick < 45) a = $urandom;
      else if (p != 0)    a = $urandom % p;
      else                a = $urandom;
      send_item(a, p);
      // let the pipe run dry once mid-run
      if (i == 250) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/minv_pkg.sv
hdl/minv_divider.sv
hdl/modular_inverse.sv
bench/modular_inverse_tb.sv
